// ----- hdl/fmsd_pkg.sv -----
// ----------------------------------------------------------------------------
// fmsd_pkg
// Shared types and codes for the multi-server dispatch unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fmsd_pkg;

    localparam int unsigned ARRIVAL_W = 32;
    localparam int unsigned PTIME_W   = 16;
    localparam int unsigned JOBNUM_W  = 16;
    localparam int unsigned CFG_W     = 4;

    localparam logic [1:0] STATUS_ENQUEUED = 2'd0;
    localparam logic [1:0] STATUS_DROPPED  = 2'd1;
    localparam logic [1:0] STATUS_NO_START = 2'd2;
    localparam logic [1:0] STATUS_STARTED  = 2'd3;

    // command handed from the front to the back
    typedef struct packed {
        logic                 is_tick;
        logic [ARRIVAL_W-1:0] arrival;
        logic [PTIME_W-1:0]   work;
    } t_cmd;

    typedef struct packed {
        logic [1:0]           status;
        logic [2:0]           server_index;
        logic [ARRIVAL_W-1:0] start_time;
        logic [ARRIVAL_W-1:0] wait_ticks;
        logic [JOBNUM_W-1:0]  job_number;
    } t_result;

endpackage

`default_nettype wire

// ----- hdl/fmsd_queue.sv -----
// ----------------------------------------------------------------------------
// fmsd_queue
// Two-entry register queue used between the front and the back and on the
// result side.
// ----------------------------------------------------------------------------
`default_nettype none

module fmsd_queue #(
    parameter int unsigned WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/fmsd_front.sv -----
// ----------------------------------------------------------------------------
// fmsd_front
// Accepts input beats, classifies them and normalizes the processing time,
// then queues the command for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module fmsd_front #(
    parameter int unsigned WORK_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_push,
    output logic                                 o_full,
    input  wire logic                            i_op,
    input  wire logic [fmsd_pkg::ARRIVAL_W-1:0]  i_arrival_time,
    input  wire logic [fmsd_pkg::PTIME_W-1:0]    i_processing_time,
    input  wire logic                            i_cmd_pop,
    output fmsd_pkg::t_cmd                       o_cmd,
    output logic                                 o_cmd_empty
);

    import fmsd_pkg::*;

    localparam logic [PTIME_W-1:0] WORK_CAP = (WORK_BITS >= PTIME_W) ? {PTIME_W{1'b1}} :
        PTIME_W'((32'd1 << WORK_BITS) - 32'd1);

    t_cmd             cmd;
    logic [PTIME_W-1:0] ptime;

    always_comb begin
        // zero work would wrap the server countdown to its maximum
        ptime = (i_processing_time == '0) ? PTIME_W'(1) : i_processing_time;
        if (ptime > WORK_CAP) begin
            ptime = WORK_CAP;
        end
        cmd.is_tick = i_op;
        cmd.arrival = i_arrival_time;
        cmd.work    = ptime;
    end

    fmsd_queue #(
        .WIDTH ($bits(t_cmd))
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (o_cmd_empty)
    );

endmodule

`default_nettype wire

// ----- hdl/fmsd_back.sv -----
// ----------------------------------------------------------------------------
// fmsd_back
// Carries out commands: job queue, tick clock, server countdown and
// dispatch to the lowest free server, with a small result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fmsd_back #(
    parameter int unsigned NUM_SERVERS = 8,
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned WORK_BITS   = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    input  wire logic [fmsd_pkg::CFG_W-1:0]  i_cfg_data,
    output logic                             o_cfg_ready,
    input  wire fmsd_pkg::t_cmd              i_cmd,
    input  wire logic                        i_cmd_empty,
    output logic                             o_cmd_pop,
    output fmsd_pkg::t_result                o_res,
    output logic                             o_res_empty,
    input  wire logic                        i_res_pop
);

    import fmsd_pkg::*;

    localparam int unsigned QW = $clog2(QUEUE_DEPTH);
    localparam int unsigned SW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
    localparam int unsigned EW = ARRIVAL_W + PTIME_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state               r_state;
    logic [CFG_W-1:0]     r_siu;
    logic [ARRIVAL_W-1:0] r_clock;
    logic [QW-1:0]        r_head;
    logic [QW-1:0]        r_tail;
    logic [QW:0]          r_count;
    logic [WORK_BITS-1:0] r_work [NUM_SERVERS];
    logic [JOBNUM_W-1:0]  r_started;
    logic [EW-1:0]        r_jobs [QUEUE_DEPTH];
    logic [EW-1:0]        r_head_entry;

    logic                 q_full;
    logic                 res_full;
    logic                 go;
    logic                 do_enq;
    logic                 do_tick;
    logic                 exec;
    logic                 found;
    logic [SW-1:0]        idx;
    logic [SW+2:0]        idx_ext;
    logic                 start;
    logic [ARRIVAL_W-1:0] head_arr;
    logic [WORK_BITS-1:0] head_work;
    logic                 res_push;
    t_result              res;

    function automatic logic [QW-1:0] next_slot(input logic [QW-1:0] p);
        return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign q_full      = (r_count == (QW+1)'(QUEUE_DEPTH));
    assign go          = (r_state == ST_IDLE) && !i_cmd_empty && !res_full;
    assign o_cmd_pop   = go;
    assign do_enq      = go && !i_cmd.is_tick;
    assign do_tick     = go && i_cmd.is_tick;
    assign exec        = (r_state == ST_EXEC);
    assign head_arr    = r_head_entry[EW-1:PTIME_W];
    assign head_work   = WORK_BITS'(r_head_entry[PTIME_W-1:0]);
    assign idx_ext     = {3'b000, idx};

    // lowest free server among those in use
    always_comb begin
        found = 1'b0;
        idx   = '0;
        for (int s = NUM_SERVERS - 1; s >= 0; s--) begin
            if ((r_work[s] == '0) && (s < int'(r_siu))) begin
                found = 1'b1;
                idx   = SW'(s);
            end
        end
    end

    assign start = exec && (r_count != '0) && (r_clock >= head_arr) && found;

    always_comb begin
        res = '0;
        if (exec) begin
            if (start) begin
                res.status       = STATUS_STARTED;
                res.server_index = idx_ext[2:0];
                res.start_time   = r_clock;
                res.wait_ticks   = r_clock - head_arr;
                res.job_number   = r_started;
            end else begin
                res.status = STATUS_NO_START;
            end
        end else begin
            res.status = q_full ? STATUS_DROPPED : STATUS_ENQUEUED;
        end
    end

    assign res_push = do_enq || exec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_siu     <= CFG_W'(1);
            r_clock   <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_started <= '0;
            for (int s = 0; s < NUM_SERVERS; s++) begin
                r_work[s] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_siu <= i_cfg_data;
            end
            case (r_state)
                ST_IDLE: begin
                    if (do_enq && !q_full) begin
                        r_tail  <= next_slot(r_tail);
                        r_count <= r_count + 1'b1;
                    end
                    if (do_tick) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_state <= ST_IDLE;
                    if (start) begin
                        r_head    <= next_slot(r_head);
                        r_count   <= r_count - 1'b1;
                        r_started <= r_started + 1'b1;
                    end
                    for (int s = 0; s < NUM_SERVERS; s++) begin
                        if (start && (idx == SW'(s))) begin
                            r_work[s] <= head_work - 1'b1;
                        end else if (r_work[s] != '0) begin
                            r_work[s] <= r_work[s] - 1'b1;
                        end
                    end
                    if (r_clock != '1) begin
                        r_clock <= r_clock + 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // job store; head entry read in the cycle before the tick evaluation
    always_ff @(posedge i_clk) begin
        if (do_enq && !q_full) begin
            r_jobs[r_tail] <= {i_cmd.arrival, i_cmd.work};
        end
        r_head_entry <= r_jobs[r_head];
    end

    fmsd_queue #(
        .WIDTH ($bits(t_result))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (i_res_pop),
        .o_data  (o_res),
        .o_empty (o_res_empty)
    );

endmodule

`default_nettype wire

// ----- hdl/fifo_multi_server_dispatch_unit.sv -----
// ----------------------------------------------------------------------------
// fifo_multi_server_dispatch_unit
// Enqueue beats are handled in the idle state of the back; tick beats pass
// through the job store read, then dispatch and countdown in the exec state,
// and the back takes no new beat until it is back in the idle state.
// Input side takes up to 2 beats ahead, result side buffers 2 beats.
// Synchronous active-low reset: queue empty, servers free, clock 0, 1 server.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_multi_server_dispatch_unit #(
    parameter int unsigned NUM_SERVERS = 8,
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned WORK_BITS   = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic                            i_op,
    input  wire logic [fmsd_pkg::ARRIVAL_W-1:0]  i_arrival_time,
    input  wire logic [fmsd_pkg::PTIME_W-1:0]    i_processing_time,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [1:0]                           o_status,
    output logic [2:0]                           o_server_index,
    output logic [fmsd_pkg::ARRIVAL_W-1:0]       o_start_time,
    output logic [fmsd_pkg::ARRIVAL_W-1:0]       o_wait_ticks,
    output logic [fmsd_pkg::JOBNUM_W-1:0]        o_job_number,
    input  wire logic                            i_cfg_valid,
    input  wire logic [fmsd_pkg::CFG_W-1:0]      i_cfg_data,
    output logic                                 o_cfg_ready
);

    import fmsd_pkg::*;

    t_cmd    cmd;
    logic    cmd_empty;
    logic    cmd_pop;
    t_result res;

    fmsd_front #(
        .WORK_BITS (WORK_BITS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .o_full            (full),
        .i_op              (i_op),
        .i_arrival_time    (i_arrival_time),
        .i_processing_time (i_processing_time),
        .i_cmd_pop         (cmd_pop),
        .o_cmd             (cmd),
        .o_cmd_empty       (cmd_empty)
    );

    fmsd_back #(
        .NUM_SERVERS (NUM_SERVERS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .WORK_BITS   (WORK_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_cmd       (cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res       (res),
        .o_res_empty (empty),
        .i_res_pop   (pop)
    );

    assign o_status       = res.status;
    assign o_server_index = res.server_index;
    assign o_start_time   = res.start_time;
    assign o_wait_ticks   = res.wait_ticks;
    assign o_job_number   = res.job_number;

endmodule

`default_nettype wire
